>>> rtl/core/etd_pkg.sv
// Package for the Euler totient block: value width, divider request and
// response types shared by the sequencer top level and the divider.
// No dependencies.
package etd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic   start;
        value_t dividend;
        value_t divisor;
    } div_req_t;

    typedef struct packed {
        logic   busy;
        logic   done;
        value_t quotient;
        value_t remainder;
    } div_rsp_t;

endpackage

>>> rtl/core/etd_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on etd_pkg for the value width and the request/response structs.
module etd_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  etd_pkg::div_req_t req,
    output etd_pkg::div_rsp_t rsp
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [etd_pkg::CNT_WIDTH-1:0] cnt_reg, cnt_next;
    etd_pkg::value_t           rem_reg, rem_next;
    etd_pkg::value_t           quo_reg, quo_next;
    etd_pkg::value_t           dvs_reg, dvs_next;

    logic [etd_pkg::VALUE_WIDTH:0] shifted;
    logic [etd_pkg::VALUE_WIDTH:0] trial;

    always_comb begin
        shifted = {rem_reg, quo_reg[etd_pkg::VALUE_WIDTH-1]};
        trial   = shifted - {1'b0, dvs_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = etd_pkg::CNT_WIDTH'(etd_pkg::VALUE_WIDTH);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // trial subtract; no borrow means the quotient bit is one
            if (!trial[etd_pkg::VALUE_WIDTH]) begin
                rem_next = trial[etd_pkg::VALUE_WIDTH-1:0];
                quo_next = {quo_reg[etd_pkg::VALUE_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[etd_pkg::VALUE_WIDTH-1:0];
                quo_next = {quo_reg[etd_pkg::VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == etd_pkg::CNT_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        rsp.busy      = busy_reg;
        rsp.done      = done_reg;
        rsp.quotient  = quo_reg;
        rsp.remainder = rem_reg;
    end

endmodule

>>> rtl/core/euler_totient_trial_division_top.sv
// Euler totient by trial division: sequencer around one shared divider.
// Each item runs a chain of divides: one per trial candidate, one per
// prime-power strip and one per totient update; only one item at a time.
// The finished result sits in an output register until taken.
// Reset (aresetn, synchronous, active low) returns to idle with no result.
module euler_totient_trial_division_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_number_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_totient
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_STRIP,
        ST_SUB,
        ST_LAST,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    etd_pkg::value_t   rest_reg, rest_next;
    etd_pkg::value_t   acc_reg, acc_next;
    etd_pkg::value_t   d_reg, d_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_totient_reg, m_totient_next;
    etd_pkg::div_req_t req_reg, req_next;
    etd_pkg::div_rsp_t rsp;
    etd_pkg::value_t   n_in;
    etd_pkg::value_t   d_inc;

    etd_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .rsp     (rsp)
    );

    always_comb begin
        n_in  = etd_pkg::VALUE_WIDTH'(s_number_in);
        d_inc = d_reg + 1'b1;
    end

    always_comb begin
        state_next     = state_reg;
        rest_next      = rest_reg;
        acc_next       = acc_reg;
        d_next         = d_reg;
        m_valid_next   = m_valid_reg;
        m_totient_next = m_totient_reg;
        req_next       = req_reg;
        req_next.start = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rest_next = n_in;
                    d_next    = etd_pkg::VALUE_WIDTH'(2);
                    if (n_in <= etd_pkg::VALUE_WIDTH'(1)) begin
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        acc_next          = n_in;
                        req_next.start    = 1'b1;
                        req_next.dividend = n_in;
                        req_next.divisor  = etd_pkg::VALUE_WIDTH'(2);
                        state_next        = ST_TEST;
                    end
                end
            end
            ST_TEST: begin
                if (rsp.done) begin
                    if (d_reg > rsp.quotient) begin
                        // d*d exceeds the cofactor: what is left is 1 or a prime
                        if (rest_reg > etd_pkg::VALUE_WIDTH'(1)) begin
                            req_next.start    = 1'b1;
                            req_next.dividend = acc_reg;
                            req_next.divisor  = rest_reg;
                            state_next        = ST_LAST;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else if (rsp.remainder == '0) begin
                        rest_next         = rsp.quotient;
                        req_next.start    = 1'b1;
                        req_next.dividend = rsp.quotient;
                        req_next.divisor  = d_reg;
                        state_next        = ST_STRIP;
                    end else begin
                        d_next            = d_inc;
                        req_next.start    = 1'b1;
                        req_next.dividend = rest_reg;
                        req_next.divisor  = d_inc;
                    end
                end
            end
            ST_STRIP: begin
                if (rsp.done) begin
                    if (rsp.remainder == '0) begin
                        rest_next         = rsp.quotient;
                        req_next.start    = 1'b1;
                        req_next.dividend = rsp.quotient;
                        req_next.divisor  = d_reg;
                    end else begin
                        req_next.start    = 1'b1;
                        req_next.dividend = acc_reg;
                        req_next.divisor  = d_reg;
                        state_next        = ST_SUB;
                    end
                end
            end
            ST_SUB: begin
                if (rsp.done) begin
                    acc_next          = acc_reg - rsp.quotient;
                    d_next            = d_inc;
                    req_next.start    = 1'b1;
                    req_next.dividend = rest_reg;
                    req_next.divisor  = d_inc;
                    state_next        = ST_TEST;
                end
            end
            ST_LAST: begin
                if (rsp.done) begin
                    acc_next   = acc_reg - rsp.quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_totient_next = 32'(acc_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            req_reg.start <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            req_reg.start <= req_next.start;
        end
        rest_reg         <= rest_next;
        acc_reg          <= acc_next;
        d_reg            <= d_next;
        m_totient_reg    <= m_totient_next;
        req_reg.dividend <= req_next.dividend;
        req_reg.divisor  <= req_next.divisor;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_totient = m_totient_reg;

`ifndef SYNTHESIS
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !rsp.busy && !req_reg.start)
        else $error("divider active while sequencer idle");

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        req_reg.start |-> !rsp.busy)
        else $error("divide started while divider busy");

    a_trial_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TEST || state_reg == ST_STRIP || state_reg == ST_SUB)
        |-> d_reg >= etd_pkg::VALUE_WIDTH'(2))
        else $error("trial divisor below two");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted item did not leave idle");
`endif

endmodule
